### rtl/ckr_pkg.sv
package ckr_pkg;

  localparam int KW_COUNT = 45;
  localparam int KW_SLOTS = 16;
  localparam int CHAR_W   = 8;
  localparam int POS_W    = 4;
  localparam int IDX_W    = 7;
  localparam int STR_W    = KW_SLOTS * CHAR_W;

  typedef logic [KW_COUNT-1:0] kw_mask_t;
  typedef logic [POS_W-1:0]    pos_t;
  typedef logic [CHAR_W-1:0]   char_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [STR_W-1:0]    kw_str_t;

  localparam pos_t     POS_MAX        = {POS_W{1'b1}};
  localparam pos_t     MAX_WORD_LEN   = POS_W'(14);
  localparam kw_mask_t ALL_CANDIDATES = {KW_COUNT{1'b1}};
  localparam idx_t     NO_MATCH       = {IDX_W{1'b1}};

  // Keyword text, right-justified: the first character of a keyword of
  // length n sits in byte n-1 counted from the least significant end.
  localparam kw_str_t KW_STR [KW_COUNT] = '{
    STR_W'("auto"),      STR_W'("break"),    STR_W'("case"),     STR_W'("char"),
    STR_W'("const"),     STR_W'("continue"), STR_W'("default"),  STR_W'("do"),
    STR_W'("double"),    STR_W'("else"),     STR_W'("enum"),     STR_W'("extern"),
    STR_W'("float"),     STR_W'("for"),      STR_W'("goto"),     STR_W'("if"),
    STR_W'("inline"),    STR_W'("int"),      STR_W'("long"),     STR_W'("register"),
    STR_W'("restrict"),  STR_W'("return"),   STR_W'("short"),    STR_W'("signed"),
    STR_W'("sizeof"),    STR_W'("static"),   STR_W'("struct"),   STR_W'("switch"),
    STR_W'("typedef"),   STR_W'("union"),    STR_W'("unsigned"), STR_W'("void"),
    STR_W'("volatile"),  STR_W'("while"),    STR_W'("_Alignas"), STR_W'("_Alignof"),
    STR_W'("_Atomic"),   STR_W'("_Bool"),    STR_W'("_Complex"), STR_W'("_Generic"),
    STR_W'("_Imaginary"), STR_W'("_Noreturn"), STR_W'("_Static_assert"),
    STR_W'("_Thread_local"), STR_W'("__func__")
  };

  localparam pos_t KW_LEN [KW_COUNT] = '{
    4'd4, 4'd5, 4'd4, 4'd4, 4'd5, 4'd8, 4'd7, 4'd2,
    4'd6, 4'd4, 4'd4, 4'd6, 4'd5, 4'd3, 4'd4, 4'd2,
    4'd6, 4'd3, 4'd4, 4'd8, 4'd8, 4'd6, 4'd5, 4'd6,
    4'd6, 4'd6, 4'd6, 4'd6, 4'd7, 4'd5, 4'd8, 4'd4,
    4'd8, 4'd5, 4'd8, 4'd8, 4'd7, 4'd5, 4'd8, 4'd8,
    4'd10, 4'd9, 4'd14, 4'd13, 4'd8
  };

endpackage

### rtl/ckr_in_if.sv
interface ckr_in_if;
  logic          valid;
  logic          ready;
  ckr_pkg::char_t key_char;
  logic          last_char;

  modport source (output valid, output key_char, output last_char, input ready);
  modport sink   (input valid, input key_char, input last_char, output ready);
endinterface

### rtl/ckr_out_if.sv
interface ckr_out_if;
  logic               valid;
  logic               ready;
  logic signed [ckr_pkg::IDX_W-1:0] match_index;

  modport source (output valid, output match_index, input ready);
  modport sink   (input valid, input match_index, output ready);
endinterface

### rtl/c_keyword_recognizer.sv
// A word's result is registered, valid in the cycle after its last character is taken.
// One character per cycle unless stalled; the candidate mask update and the final priority
// pick both sit in the single stage between the state registers and the result register.
// Reset (rst_n low, synchronous): every keyword becomes a candidate again, the position
// counter returns to zero and the result register is emptied.
module c_keyword_recognizer (
  input  logic   clk,
  input  logic   rst_n,
  ckr_in_if.sink   in_chan,
  ckr_out_if.source out_chan
);

  // Running state of the word being scanned: one candidate bit per keyword and the
  // number of characters already taken, saturating at the counter's top value.
  ckr_pkg::kw_mask_t mask_r, mask_nxt, mask_hit;
  ckr_pkg::pos_t     pos_r, pos_nxt;

  // Result register. It decouples the two sides, so a new character can be taken
  // in the same cycle that a waiting result is handed over.
  logic              out_valid_r, out_valid_nxt;
  ckr_pkg::idx_t     match_r, match_nxt;
  ckr_pkg::idx_t     result;

  logic in_fire;

  // A character is taken whenever the result register is empty or drains now.
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_fire       = in_chan.valid && in_chan.ready;

  // Per-keyword compare: a keyword stays a candidate only if the word is still no
  // longer than the keyword and the character at this position agrees with it.
  for (genvar k = 0; k < ckr_pkg::KW_COUNT; k++) begin : g_kw
    ckr_pkg::pos_t    back_pos;
    ckr_pkg::char_t   kw_char;
    logic             in_range;

    assign in_range = (pos_r < ckr_pkg::MAX_WORD_LEN) && (pos_r < ckr_pkg::KW_LEN[k]);
    assign back_pos = ckr_pkg::KW_LEN[k] - pos_r - ckr_pkg::pos_t'(1);
    assign kw_char  = ckr_pkg::KW_STR[k][{back_pos, 3'b000} +: ckr_pkg::CHAR_W];
    assign mask_hit[k] = in_range && (kw_char == in_chan.key_char);
  end

  assign mask_nxt = mask_r & mask_hit;

  // On the last character, the lowest-indexed surviving keyword whose length equals
  // the word length is the answer; exact matches are unique, so order only matters
  // in form.
  always_comb begin
    result = ckr_pkg::NO_MATCH;
    for (int k = ckr_pkg::KW_COUNT - 1; k >= 0; k--) begin
      if (mask_nxt[k] &&
          ({1'b0, ckr_pkg::KW_LEN[k]} == ({1'b0, pos_r} + (ckr_pkg::POS_W + 1)'(1)))) begin
        result = ckr_pkg::idx_t'(k);
      end
    end
  end

  always_comb begin
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r;
    match_nxt     = match_r;
    if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      if (in_chan.last_char) begin
        // The word ends here: post the answer and start the next word fresh.
        pos_nxt       = '0;
        out_valid_nxt = 1'b1;
        match_nxt     = result;
      end else if (pos_r != ckr_pkg::POS_MAX) begin
        pos_nxt = pos_r + ckr_pkg::pos_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= ckr_pkg::ALL_CANDIDATES;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        mask_r <= in_chan.last_char ? ckr_pkg::ALL_CANDIDATES : mask_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    match_r <= match_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.match_index = match_r;

  // A word's final character always produces a result in the next cycle.
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_chan.last_char |=> out_valid_r)
    else $error("last character did not produce a result");

  // After a word ends the scan state is back at its starting point.
  a_word_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_chan.last_char |=> (pos_r == '0) && (mask_r == ckr_pkg::ALL_CANDIDATES))
    else $error("scan state not restarted after a word");

  // At the start of a word no keyword has been ruled out yet.
  a_fresh_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r == '0) |-> (mask_r == ckr_pkg::ALL_CANDIDATES))
    else $error("candidate mask not full at word start");

  // A posted result is either a real keyword index or the no-match code.
  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (match_r == ckr_pkg::NO_MATCH) ||
                    (match_r < ckr_pkg::idx_t'(ckr_pkg::KW_COUNT)))
    else $error("result index out of range");

  // Input stalls only because a result is waiting to be taken.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> out_valid_r && !out_chan.ready)
    else $error("input stalled without a pending result");

endmodule
